FILE: sv/alfl_pkg.sv
`default_nettype none

package alfl_pkg;

	localparam int CMD_W    = 2;
	localparam int KEY_W    = 32;
	localparam int STATUS_W = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

endpackage

`default_nettype wire

FILE: sv/alfl_if.sv
`default_nettype none

interface alfl_req_if
	import alfl_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [KEY_W-1:0] key;

	modport source (output valid, output cmd, output key, input ready);
	modport sink (input valid, input cmd, input key, output ready);
endinterface

interface alfl_rsp_if
	import alfl_pkg::*;
#(
	parameter int SLOTS = 16
) ();
	localparam int AW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [AW-1:0]       slot;
	logic [LW-1:0]       list_head;

	modport source (output valid, output status, output slot, output list_head, input ready);
	modport sink (input valid, input status, input slot, input list_head, output ready);
endinterface

`default_nettype wire

FILE: sv/alfl_ram.sv
`default_nettype none

module alfl_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 43
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: sv/array_linked_list_with_free_list_top.sv
`default_nettype none

// Pool of SLOTS keys kept as a doubly linked list, with free slots on a singly linked free
// list; every slot's key, valid flag and both links live in one synchronous memory with a
// single read and a single write port. One command is handled at a time. The key match of a
// search or delete walks the memory one slot per cycle through its read port, and each link
// update is a read followed by a write. After reset the block builds the initial free list in
// the memory and accepts no command until it is done.
// A new command is taken while the previous result still waits on the response side.
module array_linked_list_with_free_list_top
	import alfl_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	alfl_req_if.sink  req,
	alfl_rsp_if.source rsp
);

	localparam int AW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);
	localparam int EW = 1 + KEY_W + 2 * LW;
	localparam logic [LW-1:0] NIL = LW'(SLOTS);
	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

	typedef enum logic [3:0] {
		CLEAR, IDLE, INS_RD, INS_WR, HD_RD, HD_WR, SCAN,
		DEL_S, P_RD, P_WR, N_RD, N_WR, FINISH
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic [LW-1:0]       head_q;
	logic [LW-1:0]       free_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [AW-1:0]       tgt_q;
	logic [AW-1:0]       scan_q;
	logic                chk_q;
	logic [AW-1:0]       chk_idx_q;
	logic [AW-1:0]       res_slot_q;
	logic [STATUS_W-1:0] status_q;
	logic [LW-1:0]       p_q;
	logic [LW-1:0]       n_q;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [AW-1:0]       rsp_slot_q;
	logic [LW-1:0]       rsp_head_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [EW-1:0] mem_rdata;

	logic             rd_valid;
	logic [KEY_W-1:0] rd_key;
	logic [LW-1:0]    rd_next;
	logic [LW-1:0]    rd_prev;
	logic             hit;

	assign rd_valid = mem_rdata[EW-1];
	assign rd_key   = mem_rdata[EW-2 -: KEY_W];
	assign rd_next  = mem_rdata[2*LW-1 -: LW];
	assign rd_prev  = mem_rdata[LW-1:0];
	assign hit      = chk_q && rd_valid && (rd_key == key_q);

	alfl_ram #(
		.DEPTH(SLOTS),
		.WIDTH(EW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tgt_q;
		mem_wdata = '0;
		mem_raddr = tgt_q;
		unique case (state_q)
			CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = {1'b0, {KEY_W{1'b0}}, LW'(clr_q) + LW'(1), NIL};
			end
			SCAN: begin
				mem_raddr = scan_q;
			end
			INS_WR: begin
				mem_we    = 1'b1;
				mem_wdata = {1'b1, key_q, head_q, NIL};
			end
			HD_WR: begin
				mem_we    = 1'b1;
				mem_wdata = {mem_rdata[EW-1:LW], LW'(res_slot_q)};
			end
			DEL_S: begin
				mem_we    = 1'b1;
				mem_waddr = res_slot_q;
				mem_wdata = {1'b0, key_q, free_q, p_q};
			end
			P_WR: begin
				mem_we    = 1'b1;
				mem_wdata = {mem_rdata[EW-1:2*LW], n_q, rd_prev};
			end
			N_WR: begin
				mem_we    = 1'b1;
				mem_wdata = {mem_rdata[EW-1:LW], p_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CLEAR;
			clr_q       <= '0;
			head_q      <= NIL;
			free_q      <= '0;
			chk_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.ready && state_q != FINISH) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (req.valid) begin
						cmd_q <= req.cmd;
						key_q <= req.key;
						scan_q <= '0;
						chk_q <= 1'b0;
						unique case (req.cmd)
							CMD_INSERT: begin
								if (free_q == NIL) begin
									status_q <= ST_FULL;
									state_q  <= FINISH;
								end else begin
									tgt_q   <= free_q[AW-1:0];
									state_q <= INS_RD;
								end
							end
							CMD_DELETE, CMD_SEARCH: begin
								state_q <= SCAN;
							end
							default: begin
								status_q <= ST_MISS;
								state_q  <= FINISH;
							end
						endcase
					end
				end
				INS_RD: begin
					state_q <= INS_WR;
				end
				INS_WR: begin
					free_q     <= rd_next;
					res_slot_q <= tgt_q;
					head_q     <= LW'(tgt_q);
					status_q   <= ST_OK;
					if (head_q != NIL) begin
						tgt_q   <= head_q[AW-1:0];
						state_q <= HD_RD;
					end else begin
						state_q <= FINISH;
					end
				end
				HD_RD: begin
					state_q <= HD_WR;
				end
				HD_WR: begin
					state_q <= FINISH;
				end
				SCAN: begin
					if (scan_q != LAST) begin
						scan_q <= scan_q + AW'(1);
					end
					chk_q     <= 1'b1;
					chk_idx_q <= scan_q;
					if (hit) begin
						res_slot_q <= chk_idx_q;
						p_q        <= rd_prev;
						n_q        <= rd_next;
						status_q   <= ST_OK;
						state_q    <= (cmd_q == CMD_DELETE) ? DEL_S : FINISH;
					end else if (chk_q && chk_idx_q == LAST) begin
						status_q <= ST_MISS;
						state_q  <= FINISH;
					end
				end
				DEL_S: begin
					free_q <= LW'(res_slot_q);
					if (p_q != NIL) begin
						tgt_q   <= p_q[AW-1:0];
						state_q <= P_RD;
					end else begin
						head_q <= n_q;
						if (n_q != NIL) begin
							tgt_q   <= n_q[AW-1:0];
							state_q <= N_RD;
						end else begin
							state_q <= FINISH;
						end
					end
				end
				P_RD: begin
					state_q <= P_WR;
				end
				P_WR: begin
					if (n_q != NIL) begin
						tgt_q   <= n_q[AW-1:0];
						state_q <= N_RD;
					end else begin
						state_q <= FINISH;
					end
				end
				N_RD: begin
					state_q <= N_WR;
				end
				N_WR: begin
					state_q <= FINISH;
				end
				FINISH: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_q;
						rsp_slot_q   <= (status_q == ST_OK) ? res_slot_q : '0;
						rsp_head_q   <= head_q;
						state_q      <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign req.ready     = (state_q == IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.slot      = rsp_slot_q;
	assign rsp.list_head = rsp_head_q;

endmodule

`default_nettype wire

FILE: sv/alfl_checker.sv
`default_nettype none

module alfl_checker
	import alfl_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic [STATUS_W-1:0]        rsp_status,
	input wire logic [$clog2(SLOTS)-1:0]   rsp_slot,
	input wire logic [$clog2(SLOTS+1)-1:0] rsp_head
);

	localparam int LW = $clog2(SLOTS + 1);

	// A result that waits for its transfer stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before transfer");

	// A failed command always reports slot zero.
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_slot == '0)
		else $error("nonzero slot on failed command");

	// The reported head is a slot or the null link.
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_head <= LW'(SLOTS))
		else $error("list head out of range");

	// Every result carries one of the defined status codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_FULL
			|| rsp_status == ST_MISS))
		else $error("undefined status code");

endmodule

bind array_linked_list_with_free_list_top alfl_checker #(
	.SLOTS(SLOTS)
) u_alfl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_status(rsp.status),
	.rsp_slot  (rsp.slot),
	.rsp_head  (rsp.list_head)
);

`default_nettype wire
